// ===== hw/rtl/sjf_pkg.sv =====
// ----------------------------------------------------------------------------
// sjf_pkg
// Shared sizes, payload types, controller/datapath interface structs and
// helper functions for the shortest-job-first scheduler.
// ----------------------------------------------------------------------------
package sjf_pkg;

  // batch and time sizing
  localparam int MAX_JOBS  = 16;
  localparam int TIME_BITS = 16;

  // fixed field widths of the channels
  localparam int IN_W   = 16;
  localparam int TICK_W = 21;
  localparam int IDX_W  = 6;
  localparam int FRAC_W = 8;
  localparam int WT_W   = TICK_W + FRAC_W;

  // derived widths
  localparam int JOB_AW    = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int CNT_W     = $clog2(MAX_JOBS + 1);
  localparam int CMP_W     = (TIME_BITS > TICK_W) ? TIME_BITS : TICK_W;
  localparam int DIV_CNT_W = $clog2(WT_W + 1);

  localparam logic [TICK_W-1:0] TICK_MAX = '1;
  localparam logic [WT_W-1:0]   WT_MAX   = '1;

  typedef logic [TIME_BITS-1:0] time_t;
  typedef logic [TICK_W-1:0]    tick_t;

  // input transaction payload
  typedef struct packed {
    logic [IN_W-1:0] arrive_time;
    logic [IN_W-1:0] run_time;
    logic            last_job;
  } sjf_in_t;

  // result transaction payload
  typedef struct packed {
    logic [IDX_W-1:0] job_index;
    tick_t            start_tick;
    tick_t            finish_tick;
    tick_t            turnaround;
    logic [WT_W-1:0]  weighted_turnaround;
    logic             last_result;
  } sjf_out_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic scan_init;
    logic scan_run;
    logic pick;
    logic finish;
    logic tat;
    logic div_start;
    logic emit;
  } sjf_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic scan_done;
    logic div_busy;
    logic out_free;
    logic batch_last;
  } sjf_sts_t;

  // keep the low TIME_BITS of an input time field
  function automatic time_t to_time(input logic [IN_W-1:0] v);
    logic [IN_W+TIME_BITS-1:0] ext;
    ext = {{TIME_BITS{1'b0}}, v};
    return ext[TIME_BITS-1:0];
  endfunction

  // clamp a wide tick value to the tick range
  function automatic tick_t sat_tick(input logic [CMP_W:0] v);
    tick_t res;
    if (v > (CMP_W+1)'(TICK_MAX)) begin
      res = TICK_MAX;
    end else begin
      res = v[TICK_W-1:0];
    end
    return res;
  endfunction

endpackage

// ===== hw/rtl/sjf_div.sv =====
// ----------------------------------------------------------------------------
// sjf_div
// Restoring divider, one quotient bit per cycle, for the Q8 weighted
// turnaround.
// ----------------------------------------------------------------------------
module sjf_div
  import sjf_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [WT_W-1:0] dividend,
  input  time_t           divisor,
  output logic            busy,
  output logic [WT_W-1:0] quotient
);

  logic                 busy_r, busy_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  time_t                rem_r, rem_nxt;
  logic [WT_W-1:0]      dq_r, dq_nxt;
  time_t                dvs_r, dvs_nxt;

  logic [TIME_BITS:0]   rem_sh;
  logic [TIME_BITS:0]   rem_sub;
  logic                 q_bit;

  // trial subtract of one step
  assign rem_sh  = {rem_r, dq_r[WT_W-1]};
  assign q_bit   = (rem_sh >= {1'b0, dvs_r});
  assign rem_sub = rem_sh - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dq_nxt   = dq_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_CNT_W'(WT_W);
      rem_nxt  = '0;
      dq_nxt   = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = q_bit ? rem_sub[TIME_BITS-1:0] : rem_sh[TIME_BITS-1:0];
      dq_nxt  = {dq_r[WT_W-2:0], q_bit};
      cnt_nxt = cnt_r - DIV_CNT_W'(1);
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // operand and partial result registers
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dq_r  <= dq_nxt;
    dvs_r <= dvs_nxt;
  end

  assign busy     = busy_r;
  assign quotient = dq_r;

endmodule

// ===== hw/rtl/sjf_dp.sv =====
// ----------------------------------------------------------------------------
// sjf_dp
// Scheduler datapath: job store, selection scan, timing arithmetic, divider
// and result register.
// ----------------------------------------------------------------------------
module sjf_dp
  import sjf_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  sjf_cmd_t cmd,
  output sjf_sts_t sts,
  input  sjf_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output sjf_out_t out_data
);

  // job store
  time_t arr_mem [MAX_JOBS];
  time_t run_mem [MAX_JOBS];

  // batch state
  logic [CNT_W-1:0]    loaded_r, loaded_nxt;
  logic [CNT_W-1:0]    sched_r, sched_nxt;
  logic [MAX_JOBS-1:0] done_r, done_nxt;
  tick_t               clock_now_r, clock_now_nxt;

  // scan pipeline
  logic [CNT_W-1:0]  issue_r, issue_nxt;
  logic              pend_valid_r, pend_valid_nxt;
  logic [JOB_AW-1:0] pend_idx_r;
  time_t             rd_arr_r, rd_run_r;

  // running winners of the scan
  logic              found_run_r, found_run_nxt;
  time_t             br_run_r, br_run_nxt;
  time_t             br_arr_r, br_arr_nxt;
  logic [JOB_AW-1:0] br_idx_r, br_idx_nxt;
  logic              found_arr_r, found_arr_nxt;
  time_t             ba_arr_r, ba_arr_nxt;
  time_t             ba_run_r, ba_run_nxt;
  logic [JOB_AW-1:0] ba_idx_r, ba_idx_nxt;

  // picked job
  logic [JOB_AW-1:0] pick_idx_r;
  time_t             pick_arr_r, pick_run_r;
  tick_t             start_r, finish_r, tat_r;

  // result register
  logic     out_valid_r, out_valid_nxt;
  sjf_out_t out_data_r;

  logic              load_en;
  logic              elig, arrived;
  logic [CMP_W-1:0]  clk_sel, sel_arr_ext, start_raw;
  logic [JOB_AW-1:0] sel_idx;
  time_t             sel_arr, sel_run;
  logic [CMP_W:0]    finish_sum;
  logic [CMP_W-1:0]  tat_diff;
  logic              div_busy;
  logic [WT_W-1:0]   div_q;
  logic [WT_W-1:0]   wt_val;
  logic              batch_last;
  logic              out_free;

  assign load_en = cmd.load && (loaded_r < CNT_W'(MAX_JOBS));

  // store write and registered scan read
  always_ff @(posedge clk) begin
    if (load_en) begin
      arr_mem[loaded_r[JOB_AW-1:0]] <= to_time(in_data.arrive_time);
      run_mem[loaded_r[JOB_AW-1:0]] <= to_time(in_data.run_time);
    end
    if (cmd.scan_run) begin
      rd_arr_r   <= arr_mem[issue_r[JOB_AW-1:0]];
      rd_run_r   <= run_mem[issue_r[JOB_AW-1:0]];
      pend_idx_r <= issue_r[JOB_AW-1:0];
    end
  end

  // candidate tests on the entry read last cycle
  assign elig    = pend_valid_r && !done_r[pend_idx_r];
  assign arrived = CMP_W'(rd_arr_r) <= CMP_W'(clock_now_r);

  // scan bookkeeping and winner tracking
  always_comb begin
    issue_nxt      = issue_r;
    pend_valid_nxt = pend_valid_r;
    found_run_nxt  = found_run_r;
    br_run_nxt     = br_run_r;
    br_arr_nxt     = br_arr_r;
    br_idx_nxt     = br_idx_r;
    found_arr_nxt  = found_arr_r;
    ba_arr_nxt     = ba_arr_r;
    ba_run_nxt     = ba_run_r;
    ba_idx_nxt     = ba_idx_r;
    if (cmd.scan_init) begin
      issue_nxt      = '0;
      pend_valid_nxt = 1'b0;
      found_run_nxt  = 1'b0;
      found_arr_nxt  = 1'b0;
    end else begin
      if (cmd.scan_run) begin
        pend_valid_nxt = (issue_r < loaded_r);
        if (issue_r < loaded_r) begin
          issue_nxt = issue_r + CNT_W'(1);
        end
      end
      // shortest run among arrived jobs
      if (elig && arrived && (!found_run_r || rd_run_r < br_run_r)) begin
        found_run_nxt = 1'b1;
        br_run_nxt    = rd_run_r;
        br_arr_nxt    = rd_arr_r;
        br_idx_nxt    = pend_idx_r;
      end
      // earliest arrival for the idle case
      if (elig && (!found_arr_r || rd_arr_r < ba_arr_r)) begin
        found_arr_nxt = 1'b1;
        ba_arr_nxt    = rd_arr_r;
        ba_run_nxt    = rd_run_r;
        ba_idx_nxt    = pend_idx_r;
      end
    end
  end

  // job choice and start time; idle case jumps the clock to the arrival
  always_comb begin
    if (found_run_r) begin
      sel_idx = br_idx_r;
      sel_arr = br_arr_r;
      sel_run = br_run_r;
      clk_sel = CMP_W'(clock_now_r);
    end else begin
      sel_idx = ba_idx_r;
      sel_arr = ba_arr_r;
      sel_run = ba_run_r;
      clk_sel = CMP_W'(ba_arr_r);
    end
    sel_arr_ext = CMP_W'(sel_arr);
    start_raw   = (clk_sel > sel_arr_ext) ? clk_sel : sel_arr_ext;
  end

  assign finish_sum = (CMP_W+1)'(start_r) + (CMP_W+1)'(pick_run_r);
  assign tat_diff   = CMP_W'(finish_r) - CMP_W'(pick_arr_r);

  // batch state updates
  always_comb begin
    loaded_nxt    = loaded_r;
    sched_nxt     = sched_r;
    done_nxt      = done_r;
    clock_now_nxt = clock_now_r;
    if (load_en) begin
      loaded_nxt = loaded_r + CNT_W'(1);
    end
    if (cmd.finish) begin
      clock_now_nxt        = sat_tick(finish_sum);
      done_nxt[pick_idx_r] = 1'b1;
    end
    if (cmd.emit) begin
      sched_nxt = sched_r + CNT_W'(1);
      if (batch_last) begin
        loaded_nxt    = '0;
        sched_nxt     = '0;
        done_nxt      = '0;
        clock_now_nxt = '0;
      end
    end
  end

  assign batch_last = (sched_r + CNT_W'(1)) == loaded_r;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loaded_r     <= '0;
      sched_r      <= '0;
      done_r       <= '0;
      clock_now_r  <= '0;
      issue_r      <= '0;
      pend_valid_r <= 1'b0;
      found_run_r  <= 1'b0;
      found_arr_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      loaded_r     <= loaded_nxt;
      sched_r      <= sched_nxt;
      done_r       <= done_nxt;
      clock_now_r  <= clock_now_nxt;
      issue_r      <= issue_nxt;
      pend_valid_r <= pend_valid_nxt;
      found_run_r  <= found_run_nxt;
      found_arr_r  <= found_arr_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    br_run_r <= br_run_nxt;
    br_arr_r <= br_arr_nxt;
    br_idx_r <= br_idx_nxt;
    ba_arr_r <= ba_arr_nxt;
    ba_run_r <= ba_run_nxt;
    ba_idx_r <= ba_idx_nxt;
    if (cmd.pick) begin
      pick_idx_r <= sel_idx;
      pick_arr_r <= sel_arr;
      pick_run_r <= sel_run;
      start_r    <= sat_tick({1'b0, start_raw});
    end
    if (cmd.finish) begin
      finish_r <= sat_tick(finish_sum);
    end
    if (cmd.tat) begin
      tat_r <= (CMP_W'(finish_r) >= CMP_W'(pick_arr_r)) ? tat_diff[TICK_W-1:0] : '0;
    end
    if (cmd.emit) begin
      out_data_r.job_index           <= IDX_W'(pick_idx_r);
      out_data_r.start_tick          <= start_r;
      out_data_r.finish_tick         <= finish_r;
      out_data_r.turnaround          <= tat_r;
      out_data_r.weighted_turnaround <= wt_val;
      out_data_r.last_result         <= batch_last;
    end
  end

  // weighted turnaround divider, zero run saturates
  sjf_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend ({tat_r, {FRAC_W{1'b0}}}),
    .divisor  (pick_run_r),
    .busy     (div_busy),
    .quotient (div_q)
  );

  assign wt_val = (pick_run_r == '0) ? WT_MAX : div_q;

  // result register handshake
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign sts.scan_done  = (issue_r == loaded_r) && !pend_valid_r;
  assign sts.div_busy   = div_busy;
  assign sts.out_free   = out_free;
  assign sts.batch_last = batch_last;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== hw/rtl/sjf_ctrl.sv =====
// ----------------------------------------------------------------------------
// sjf_ctrl
// Scheduler controller: loads jobs, then steps the datapath through scan,
// pick, timing, divide and result for each job of the batch.
// ----------------------------------------------------------------------------
module sjf_ctrl
  import sjf_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_last,
  output logic     in_ready,
  input  sjf_sts_t sts,
  output sjf_cmd_t cmd
);

  localparam logic [2:0] S_LOAD = 3'd0;
  localparam logic [2:0] S_INIT = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_PICK = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;
  localparam logic [2:0] S_TAT  = 3'd5;
  localparam logic [2:0] S_DIV  = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic       div_issued_r, div_issued_nxt;

  // next state and commands
  always_comb begin
    state_nxt      = state_r;
    div_issued_nxt = div_issued_r;
    cmd            = '0;
    in_ready       = 1'b0;
    unique case (state_r)
      S_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_last) begin
            state_nxt = S_INIT;
          end
        end
      end
      S_INIT: begin
        cmd.scan_init = 1'b1;
        state_nxt     = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_run = 1'b1;
        if (sts.scan_done) begin
          state_nxt = S_PICK;
        end
      end
      S_PICK: begin
        cmd.pick  = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_nxt  = S_TAT;
      end
      S_TAT: begin
        cmd.tat        = 1'b1;
        div_issued_nxt = 1'b0;
        state_nxt      = S_DIV;
      end
      S_DIV: begin
        // start once, then wait for the last quotient bit
        if (!div_issued_r) begin
          cmd.div_start  = 1'b1;
          div_issued_nxt = 1'b1;
        end else if (!sts.div_busy) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = sts.batch_last ? S_LOAD : S_INIT;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_LOAD;
      div_issued_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      div_issued_r <= div_issued_nxt;
    end
  end

endmodule

// ===== hw/rtl/shortest_job_first_scheduler_core.sv =====
// ----------------------------------------------------------------------------
// shortest_job_first_scheduler_core
// Non-preemptive shortest-job-first scheduler: loads a batch of jobs, then
// emits one timing result per job in schedule order.
//
//   channel | direction | handshake            | payload
//   in_     | input     | in_valid / in_ready   | sjf_in_t  (arrive, run, last)
//   out_    | output    | out_valid / out_ready | sjf_out_t (index, times, wt)
//
// Loading accepts one job transaction per cycle while the input is open.
// For each result, the store entries of the batch are scanned one per cycle,
// and the Q8 divide retires one quotient bit per cycle.
// Reset is synchronous; the job store is not cleared (entries are always
// written before they are read), so no clearing pass follows reset.
// A stalled result holds in the output register; the next job is still scanned
// and timed, and its result waits only when that register is still full.
// ----------------------------------------------------------------------------
module shortest_job_first_scheduler_core
  import sjf_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  sjf_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output sjf_out_t out_data
);

  sjf_cmd_t cmd;
  sjf_sts_t sts;

  // sequencer
  sjf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_last  (in_data.last_job),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // store, scan, arithmetic and result register
  sjf_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // a result is never written over one still waiting
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> sts.out_free)
    else $error("result register overwritten");

  // the divider is only started when idle
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> !sts.div_busy)
    else $error("divider restarted while busy");

  // the final job of a batch closes the input side
  a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_data.last_job) |=> !in_ready)
    else $error("input still open after last job");

  // one datapath command per cycle
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.scan_init, cmd.scan_run, cmd.pick, cmd.finish,
              cmd.tat, cmd.div_start, cmd.emit}))
    else $error("overlapping datapath commands");

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the shortest-job-first scheduler core. Job
// transactions are loaded in batches; an in-bench scheduler works out the
// expected timing result of every job of a batch once its last job is
// accepted. Each result transaction is then checked field by field, in order.
// Both channels idle and stall at random, with one burst stretch at full rate.
// ----------------------------------------------------------------------------
module tb;
  import sjf_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 120;
  localparam int RANDOM_JOBS = 360;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  sjf_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  sjf_out_t out_data;

  // scheduler state mirrored by the bench
  time_t    job_arrival [MAX_JOBS];
  time_t    job_run [MAX_JOBS];
  int       jobs_loaded;
  sjf_out_t due_results[$];
  sjf_out_t next_due;

  int  mismatch_count;
  int  cycle_count;
  bit  burst_mode;

  shortest_job_first_scheduler_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // run-length guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // one line per mismatch, counting all
  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    $display("mismatch %s at cycle %0d: got %0d expected %0d",
             what, cycle_count, got, want);
    mismatch_count++;
  endtask

  // non-preemptive sjf over the loaded batch, queues one result per job
  task automatic schedule_batch();
    logic [MAX_JOBS-1:0] finished;
    longint unsigned     now_tick;
    longint unsigned     best;
    longint unsigned     start;
    longint unsigned     fin;
    longint unsigned     tat;
    longint unsigned     wt;
    int                  pick;
    bit                  found;
    sjf_out_t            res;
    finished = '0;
    now_tick = 0;
    for (int k = 0; k < jobs_loaded; k++) begin
      found = 1'b0;
      pick = 0;
      best = 0;
      // shortest run among arrived jobs, lowest index on ties
      for (int i = 0; i < jobs_loaded; i++) begin
        if (!finished[i] && job_arrival[i] <= now_tick) begin
          if (!found || job_run[i] < best) begin
            found = 1'b1;
            best = job_run[i];
            pick = i;
          end
        end
      end
      // nothing arrived: jump to the earliest arrival
      if (!found) begin
        for (int i = 0; i < jobs_loaded; i++) begin
          if (!finished[i]) begin
            if (!found || job_arrival[i] < best) begin
              found = 1'b1;
              best = job_arrival[i];
              pick = i;
            end
          end
        end
        now_tick = (best > TICK_MAX) ? TICK_MAX : best;
      end
      start = (now_tick > job_arrival[pick]) ? now_tick : job_arrival[pick];
      fin = start + job_run[pick];
      if (start > TICK_MAX) start = TICK_MAX;
      if (fin > TICK_MAX) fin = TICK_MAX;
      tat = (fin >= job_arrival[pick]) ? fin - job_arrival[pick] : 0;
      if (job_run[pick] == 0) begin
        wt = WT_MAX;
      end else begin
        wt = (tat << FRAC_W) / job_run[pick];
        if (wt > WT_MAX) wt = WT_MAX;
      end
      now_tick = fin;
      finished[pick] = 1'b1;
      res.job_index = IDX_W'(pick);
      res.start_tick = TICK_W'(start);
      res.finish_tick = TICK_W'(fin);
      res.turnaround = TICK_W'(tat);
      res.weighted_turnaround = WT_W'(wt);
      res.last_result = (k == jobs_loaded - 1);
      due_results.push_back(res);
    end
    jobs_loaded = 0;
  endtask

  // monitor: load accepted jobs, check accepted results
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      if (jobs_loaded < MAX_JOBS) begin
        job_arrival[jobs_loaded] = time_t'(in_data.arrive_time);
        job_run[jobs_loaded] = time_t'(in_data.run_time);
        jobs_loaded++;
      end
      if (in_data.last_job) schedule_batch();
    end
    if (rst_n && out_valid && out_ready) begin
      if (due_results.size() == 0) begin
        report_mismatch("unexpected result, job_index", out_data.job_index, 0);
      end else begin
        next_due = due_results.pop_front();
        if (out_data.job_index !== next_due.job_index)
          report_mismatch("job_index", out_data.job_index, next_due.job_index);
        if (out_data.start_tick !== next_due.start_tick)
          report_mismatch("start_tick", out_data.start_tick, next_due.start_tick);
        if (out_data.finish_tick !== next_due.finish_tick)
          report_mismatch("finish_tick", out_data.finish_tick, next_due.finish_tick);
        if (out_data.turnaround !== next_due.turnaround)
          report_mismatch("turnaround", out_data.turnaround, next_due.turnaround);
        if (out_data.weighted_turnaround !== next_due.weighted_turnaround)
          report_mismatch("weighted_turnaround", out_data.weighted_turnaround,
                          next_due.weighted_turnaround);
        if (out_data.last_result !== next_due.last_result)
          report_mismatch("last_result", out_data.last_result, next_due.last_result);
      end
    end
  end

  // result side backpressure
  always @(negedge clk) begin
    out_ready <= burst_mode || ($urandom_range(99) >= 32);
  end

  // drive one job transaction and wait until it is taken
  task automatic send_job(input logic [IN_W-1:0] arrive, input logic [IN_W-1:0] run,
                          input logic last);
    sjf_in_t job;
    job.arrive_time = arrive;
    job.run_time = run;
    job.last_job = last;
    @(negedge clk);
    while (!burst_mode && $urandom_range(99) < 32) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= job;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // hold off the sender until every queued result has come out
  task automatic wait_results_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // single-job batches at the field extremes, zero run and zero turnaround
  task automatic test_single_extremes();
    send_job(16'h0000, 16'h0000, 1'b1);
    send_job(16'hffff, 16'hffff, 1'b1);
    wait_results_drained();
  endtask

  // no job at tick zero: lowest index of the earliest arrival wins over a shorter run
  task automatic test_idle_jump();
    send_job(16'd100, 16'd5, 1'b0);
    send_job(16'd10, 16'd9, 1'b0);
    send_job(16'd10, 16'd3, 1'b1);
    wait_results_drained();
  endtask

  // equal runs all ready at once go in load order
  task automatic test_tie_break();
    send_job(16'd0, 16'd7, 1'b0);
    send_job(16'd0, 16'd7, 1'b0);
    send_job(16'd0, 16'd7, 1'b1);
    wait_results_drained();
  endtask

  // full batch of long late jobs, then a dropped job that still closes the batch
  task automatic test_batch_overflow();
    for (int i = 0; i < MAX_JOBS; i++) begin
      send_job(16'hffff - 16'(i), 16'hffff - 16'(3 * i), 1'b0);
    end
    send_job(16'd1, 16'd1, 1'b1);
    wait_results_drained();
  endtask

  // random batches, mostly contended, some sparse, a few oversized
  task automatic test_random_batches();
    int batch_len;
    int flavor;
    int sent;
    logic [IN_W-1:0] arrive;
    logic [IN_W-1:0] run;
    sent = 0;
    while (sent < RANDOM_JOBS) begin
      burst_mode = (sent >= 120 && sent < 200);
      if ($urandom_range(9) == 0) begin
        batch_len = $urandom_range(MAX_JOBS + 4, MAX_JOBS + 1);
      end else if ($urandom_range(3) == 0) begin
        batch_len = $urandom_range(MAX_JOBS, 1);
      end else begin
        batch_len = $urandom_range(6, 1);
      end
      flavor = $urandom_range(3);
      for (int i = 0; i < batch_len; i++) begin
        case (flavor)
          0: begin
            arrive = 16'($urandom_range(63));
            run = 16'($urandom_range(31));
          end
          1: begin
            arrive = 16'($urandom);
            run = 16'($urandom);
          end
          2: begin
            arrive = 16'($urandom_range(2000));
            run = ($urandom_range(4) == 0) ? 16'h0000 : 16'($urandom_range(300));
          end
          default: begin
            arrive = ($urandom_range(1) == 0) ? 16'hffff : 16'($urandom);
            run = ($urandom_range(1) == 0) ? 16'hffff : 16'($urandom_range(7));
          end
        endcase
        send_job(arrive, run, i == batch_len - 1);
        sent++;
      end
      if ($urandom_range(3) == 0) wait_results_drained();
    end
    burst_mode = 1'b0;
    wait_results_drained();
  endtask

  // sequence of tests
  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    jobs_loaded = 0;
    mismatch_count = 0;
    cycle_count = 0;
    burst_mode = 1'b0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    test_single_extremes();
    test_idle_jump();
    test_tie_break();
    test_batch_overflow();
    test_random_batches();

    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/sjf_pkg.sv
hw/rtl/sjf_div.sv
hw/rtl/sjf_dp.sv
hw/rtl/sjf_ctrl.sv
hw/rtl/shortest_job_first_scheduler_core.sv
tb/tb.sv
